FILE: rtl/dbra_pkg.sv
package dbra_pkg;

  localparam int SAMPLE_W = 16;
  localparam int BIN_W    = 10;
  localparam int STOP_W   = 11;
  localparam int ACC_W    = 48;
  localparam int PROD_W   = 32;
  localparam int MAG_W    = 47;
  localparam int PH_W     = 16;
  localparam int BIN_LIMIT = 1024;
  localparam int CORDIC_STEPS = 24;

  // Register indexes on the APB port (word address bit 2)
  localparam logic REG_BIN_START = 1'b0;
  localparam logic REG_BIN_STOP  = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic issue;
    logic clear;
    logic post_start;
  } cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic post_done;
  } status_t;

  // arctan(2^-i) in units of pi/2^31
  function automatic logic [29:0] atan_step(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004758;
      5'd4:  v = 30'd42667333;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/dbra_ctrl.sv
module dbra_ctrl #(
  parameter int POINTS   = 1024,
  parameter int MAX_BINS = 64,
  parameter int PW       = $clog2(POINTS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        sample_valid_i,
  output logic                        sample_ready_o,
  input  logic [dbra_pkg::BIN_W-1:0]  bin_start_i,
  input  logic [dbra_pkg::STOP_W-1:0] stop_eff_i,
  input  dbra_pkg::status_t           status_i,
  output dbra_pkg::cmd_t              cmd_o,
  output logic [PW-1:0]               wr_addr_o,
  output logic [PW-1:0]               rd_addr_o,
  output logic [PW-1:0]               tw_addr_o,
  input  logic                        result_ready_i,
  output logic                        result_valid_o,
  output logic [dbra_pkg::BIN_W-1:0]  bin_index_o,
  output logic                        last_bin_o
);

  localparam int KW  = (PW > dbra_pkg::BIN_W) ? PW : dbra_pkg::BIN_W;
  localparam int NBW = $clog2(MAX_BINS + 1);
  localparam logic [KW:0]   POINTS_K = (KW + 1)'(POINTS);
  localparam logic [PW:0]   POINTS_M = (PW + 1)'(POINTS);
  localparam logic [PW-1:0] LAST_IDX = PW'(POINTS - 1);
  localparam logic [NBW-1:0] LAST_NB = NBW'(MAX_BINS - 1);

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_MOD     = 3'd1;
  localparam logic [2:0] S_MAC     = 3'd2;
  localparam logic [2:0] S_DRAIN   = 3'd3;
  localparam logic [2:0] S_POST    = 3'd4;
  localparam logic [2:0] S_OUT     = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic [PW-1:0]              cnt_q, i_q, m_q;
  logic [KW-1:0]              kmod_q;
  logic [dbra_pkg::BIN_W-1:0] k_q;
  logic [NBW-1:0]             nb_q;

  logic                       in_acc, frame_end, range_ok, is_last;
  logic [PW:0]                msum;
  logic [KW:0]                kinc;
  logic [dbra_pkg::STOP_W-1:0] knext;

  assign sample_ready_o = (state_q == S_COLLECT);
  assign in_acc    = sample_valid_i && sample_ready_o;
  assign frame_end = in_acc && (cnt_q == LAST_IDX);
  assign range_ok  = {1'b0, bin_start_i} < stop_eff_i;
  assign msum      = {1'b0, m_q} + {1'b0, kmod_q[PW-1:0]};
  assign kinc      = {1'b0, kmod_q} + (KW + 1)'(1);
  assign knext     = {1'b0, k_q} + dbra_pkg::STOP_W'(1);
  assign is_last   = (knext >= stop_eff_i) || (nb_q == LAST_NB);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_COLLECT: if (frame_end && range_ok) state_d = S_MOD;
      S_MOD:     if ({1'b0, kmod_q} < POINTS_K) state_d = S_MAC;
      S_MAC:     if (i_q == LAST_IDX) state_d = S_DRAIN;
      S_DRAIN:   if (!status_i.mac_busy) state_d = S_POST;
      S_POST:    if (status_i.post_done) state_d = S_OUT;
      S_OUT: begin
        if (result_ready_i) state_d = is_last ? S_COLLECT : S_MAC;
      end
      default:   state_d = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
      cnt_q   <= '0;
      i_q     <= '0;
      m_q     <= '0;
      kmod_q  <= '0;
      k_q     <= '0;
      nb_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_COLLECT: begin
          if (in_acc) cnt_q <= frame_end ? '0 : cnt_q + PW'(1);
          if (frame_end) begin
            k_q    <= bin_start_i;
            kmod_q <= KW'(bin_start_i);
            nb_q   <= '0;
            i_q    <= '0;
            m_q    <= '0;
          end
        end
        S_MOD: begin
          // reduce the first bin modulo the frame length
          if ({1'b0, kmod_q} >= POINTS_K) kmod_q <= KW'({1'b0, kmod_q} - POINTS_K);
        end
        S_MAC: begin
          i_q <= i_q + PW'(1);
          m_q <= (msum >= POINTS_M) ? PW'(msum - POINTS_M) : msum[PW-1:0];
        end
        S_OUT: begin
          if (result_ready_i && !is_last) begin
            k_q    <= k_q + dbra_pkg::BIN_W'(1);
            kmod_q <= (kinc == POINTS_K) ? '0 : kinc[KW-1:0];
            nb_q   <= nb_q + NBW'(1);
            i_q    <= '0;
            m_q    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd_o.wr_en      = in_acc;
    cmd_o.issue      = (state_q == S_MAC);
    cmd_o.clear      = ((state_q == S_MOD) && (state_d == S_MAC)) ||
                       ((state_q == S_OUT) && (state_d == S_MAC));
    cmd_o.post_start = (state_q == S_DRAIN) && (state_d == S_POST);
  end

  assign wr_addr_o      = cnt_q;
  assign rd_addr_o      = i_q;
  assign tw_addr_o      = m_q;
  assign result_valid_o = (state_q == S_OUT);
  assign bin_index_o    = k_q;
  assign last_bin_o     = is_last;

endmodule

FILE: rtl/dbra_mac.sv
module dbra_mac #(
  parameter int POINTS = 1024,
  parameter int PW     = $clog2(POINTS)
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dbra_pkg::cmd_t                          cmd_i,
  input  logic [PW-1:0]                           wr_addr_i,
  input  logic [PW-1:0]                           rd_addr_i,
  input  logic [PW-1:0]                           tw_addr_i,
  input  logic signed [dbra_pkg::SAMPLE_W-1:0]    sample_i,
  output logic                                    busy_o,
  output logic signed [dbra_pkg::ACC_W-1:0]       real_o,
  output logic signed [dbra_pkg::ACC_W-1:0]       imag_o
);

  localparam int SW = dbra_pkg::SAMPLE_W;
  typedef logic [2*SW-1:0] tw_arr_t [POINTS];

  function automatic logic [63:0] poly_sin(input logic [63:0] x);
    logic [63:0] x2, t;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824 - x2 / 42;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic logic [63:0] poly_cos(input logic [63:0] x);
    logic [63:0] x2, t;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824 - x2 / 56;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 30;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 12;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 2;
    return t;
  endfunction

  function automatic logic [SW-1:0] to_q15(input logic [63:0] v);
    logic [63:0] r;
    r = (v + 64'd16384) >> 15;
    return (r > 64'd32767) ? SW'(32767) : r[SW-1:0];
  endfunction

  function automatic tw_arr_t build_tw();
    tw_arr_t     tab;
    logic [63:0] p, r, x;
    logic [1:0]  q;
    logic [SW-1:0] c0, s0;
    for (int m = 0; m < POINTS; m++) begin
      p = (64'(m) << 32) / POINTS;
      q = p[31:30];
      r = {34'd0, p[29:0]};
      if (r <= 64'd536870912) begin
        x  = (r * 64'd3373259426) >> 31;
        c0 = to_q15(poly_cos(x));
        s0 = to_q15(poly_sin(x));
      end else begin
        x  = ((64'd1073741824 - r) * 64'd3373259426) >> 31;
        c0 = to_q15(poly_sin(x));
        s0 = to_q15(poly_cos(x));
      end
      case (q)
        2'd0:    tab[m] = {c0, s0};
        2'd1:    tab[m] = {-s0, c0};
        2'd2:    tab[m] = {-c0, -s0};
        default: tab[m] = {s0, -c0};
      endcase
    end
    return tab;
  endfunction

  localparam tw_arr_t TWIDDLE = build_tw();

  logic [SW-1:0]   sample_mem [POINTS];
  logic signed [SW-1:0] x_q, c_q, s_q;
  logic [2*SW-1:0] tw_q;
  logic signed [dbra_pkg::PROD_W-1:0] pc_q, ps_q;
  logic            v1_q, v2_q;
  logic signed [dbra_pkg::ACC_W-1:0] re_q, im_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) sample_mem[wr_addr_i] <= sample_i;
    if (cmd_i.issue) begin
      x_q  <= sample_mem[rd_addr_i];
      tw_q <= TWIDDLE[tw_addr_i];
    end
  end

  assign c_q = tw_q[2*SW-1:SW];
  assign s_q = tw_q[SW-1:0];

  always_ff @(posedge clk_i) begin
    pc_q <= x_q * c_q;
    ps_q <= x_q * s_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      re_q <= '0;
      im_q <= '0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.clear) begin
        re_q <= '0;
        im_q <= '0;
      end else if (v2_q) begin
        re_q <= re_q + dbra_pkg::ACC_W'(pc_q);
        im_q <= im_q - dbra_pkg::ACC_W'(ps_q);
      end
    end
  end

  assign busy_o = v1_q || v2_q;
  assign real_o = re_q;
  assign imag_o = im_q;

endmodule

FILE: rtl/dbra_post.sv
module dbra_post (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [dbra_pkg::ACC_W-1:0]    real_i,
  input  logic signed [dbra_pkg::ACC_W-1:0]    imag_i,
  output logic                                 done_o,
  output logic [dbra_pkg::MAG_W-1:0]           magnitude_o,
  output logic signed [dbra_pkg::PH_W-1:0]     phase_o
);

  localparam int AW = dbra_pkg::ACC_W;
  localparam int NW = 2 * AW;
  localparam int XW = AW + 4;
  localparam int ZW = 34;
  localparam int RW = AW + 2;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_SQR  = 3'd1;
  localparam logic [2:0] P_SQI  = 3'd2;
  localparam logic [2:0] P_ROOT = 3'd3;
  localparam logic [2:0] P_CORD = 3'd4;
  localparam logic [2:0] P_FIN  = 3'd5;

  logic [2:0]    ph_q;
  logic [5:0]    cnt_q;
  logic [NW-1:0] n_q, mcand_q;
  logic [AW-1:0] mplr_q, ai_q, ar, ai;
  logic [RW-1:0] rem_q;
  logic [AW-1:0] root_q;
  logic signed [XW-1:0] x_q, y_q, dx, dy;
  logic signed [ZW-1:0] z_q, zr, at;
  logic          zero_q;
  logic [RW+1:0] rem_sh, trial;

  assign ar = real_i[AW-1] ? AW'(-real_i) : real_i;
  assign ai = imag_i[AW-1] ? AW'(-imag_i) : imag_i;

  assign rem_sh = {rem_q, n_q[NW-1:NW-2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign dx     = y_q >>> cnt_q[4:0];
  assign dy     = x_q >>> cnt_q[4:0];
  assign at     = ZW'(dbra_pkg::atan_step(cnt_q[4:0]));
  assign zr     = (z_q + ZW'(32768)) >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= P_IDLE;
      cnt_q <= '0;
    end else begin
      case (ph_q)
        P_IDLE: if (start_i) begin
          ph_q  <= P_SQR;
          cnt_q <= '0;
        end
        P_SQR, P_SQI, P_ROOT: begin
          cnt_q <= (cnt_q == 6'(AW - 1)) ? '0 : cnt_q + 6'd1;
          if (cnt_q == 6'(AW - 1)) ph_q <= ph_q + 3'd1;
        end
        P_CORD: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(dbra_pkg::CORDIC_STEPS - 1)) ph_q <= P_FIN;
        end
        P_FIN:   ph_q <= P_IDLE;
        default: ph_q <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ph_q)
      P_IDLE: if (start_i) begin
        n_q     <= '0;
        mcand_q <= NW'(ar);
        mplr_q  <= ar;
        ai_q    <= ai;
        rem_q   <= '0;
        root_q  <= '0;
        zero_q  <= (real_i == '0) && (imag_i == '0);
        // turn the vector by pi when it points left
        if (real_i[AW-1]) begin
          x_q <= -XW'(real_i);
          y_q <= -XW'(imag_i);
          z_q <= imag_i[AW-1] ? -(ZW'(1) <<< 31) : (ZW'(1) <<< 31);
        end else begin
          x_q <= XW'(real_i);
          y_q <= XW'(imag_i);
          z_q <= '0;
        end
      end
      P_SQR, P_SQI: begin
        if (mplr_q[0]) n_q <= n_q + mcand_q;
        if ((ph_q == P_SQR) && (cnt_q == 6'(AW - 1))) begin
          mcand_q <= NW'(ai_q);
          mplr_q  <= ai_q;
        end else begin
          mcand_q <= mcand_q << 1;
          mplr_q  <= mplr_q >> 1;
        end
      end
      P_ROOT: begin
        n_q <= n_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= RW'(rem_sh - trial);
          root_q <= {root_q[AW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh[RW-1:0];
          root_q <= {root_q[AW-2:0], 1'b0};
        end
      end
      P_CORD: begin
        if (!y_q[XW-1]) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end
      end
      default: ;
    endcase
  end

  assign done_o      = (ph_q == P_FIN);
  // clamp a root beyond the output range to all ones
  assign magnitude_o = root_q[AW-1] ? '1 : root_q[dbra_pkg::MAG_W-1:0];
  assign phase_o     = zero_q ? '0 : zr[dbra_pkg::PH_W-1:0];

endmodule

FILE: rtl/dft_bin_range_analyzer.sv
// Direct DFT over a configurable range of bins, with magnitude and phase.
// Input channel: one signed Q15 sample word per handshake (sample_valid_i /
// sample_ready_o). Samples fill a POINTS-entry store; the last sample of a
// frame starts the bin sweep, and no samples are taken until the sweep ends.
// Output channel: one result word per bin k = bin_start .. min(bin_stop,1024)-1,
// at most MAX_BINS per frame, with last_bin_o set on the final word. An empty
// range gives no words and the next frame starts at once.
// Per bin: all POINTS samples pass through the single multiply-accumulate
// pair (one sample-store read and one twiddle-ROM read per cycle), the pair
// drains, then the post unit runs (96 shift-add squaring steps, 48 root
// digits, 24 CORDIC steps, 1 finish step) and the word is presented until
// taken. Once per frame the first bin is reduced modulo POINTS beforehand.
// A stalled receiver holds the current result word; the sweep resumes when
// it is taken. Reset clears the sample count and state; the registers return
// to bin_start 0, bin_stop 64. The store needs no clearing: a frame only reads
// entries written since reset.
// APB: bin_start at 0x0, bin_stop at 0x4; write only while idle.
module dft_bin_range_analyzer #(
  parameter int POINTS   = 1024,
  parameter int MAX_BINS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                sample_valid_i,
  output logic                                sample_ready_o,
  input  logic signed [dbra_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                result_valid_o,
  input  logic                                result_ready_i,
  output logic [dbra_pkg::BIN_W-1:0]          bin_index_o,
  output logic signed [dbra_pkg::ACC_W-1:0]   real_sum_o,
  output logic signed [dbra_pkg::ACC_W-1:0]   imag_sum_o,
  output logic [dbra_pkg::MAG_W-1:0]          magnitude_o,
  output logic signed [dbra_pkg::PH_W-1:0]    phase_o,
  output logic                                last_bin_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int PW = $clog2(POINTS);

  logic [dbra_pkg::BIN_W-1:0]  bin_start_q;
  logic [dbra_pkg::STOP_W-1:0] bin_stop_q, stop_eff;
  logic                        wr;
  dbra_pkg::cmd_t              cmd;
  dbra_pkg::status_t           status;
  logic [PW-1:0]               wr_addr, rd_addr, tw_addr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_start_q <= '0;
      bin_stop_q  <= dbra_pkg::STOP_W'(64);
    end else if (wr) begin
      if (paddr[2] == dbra_pkg::REG_BIN_START) bin_start_q <= pwdata[dbra_pkg::BIN_W-1:0];
      else bin_stop_q <= pwdata[dbra_pkg::STOP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == dbra_pkg::REG_BIN_STOP) ?
                  {21'd0, bin_stop_q} : {22'd0, bin_start_q};

  assign stop_eff = (bin_stop_q > dbra_pkg::STOP_W'(dbra_pkg::BIN_LIMIT)) ?
                    dbra_pkg::STOP_W'(dbra_pkg::BIN_LIMIT) : bin_stop_q;

  dbra_ctrl #(.POINTS(POINTS), .MAX_BINS(MAX_BINS), .PW(PW)) u_ctrl (
    .clk_i, .rst_ni,
    .sample_valid_i, .sample_ready_o,
    .bin_start_i(bin_start_q), .stop_eff_i(stop_eff),
    .status_i(status), .cmd_o(cmd),
    .wr_addr_o(wr_addr), .rd_addr_o(rd_addr), .tw_addr_o(tw_addr),
    .result_ready_i, .result_valid_o,
    .bin_index_o, .last_bin_o
  );

  dbra_mac #(.POINTS(POINTS), .PW(PW)) u_mac (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .wr_addr_i(wr_addr), .rd_addr_i(rd_addr), .tw_addr_i(tw_addr),
    .sample_i, .busy_o(status.mac_busy),
    .real_o(real_sum_o), .imag_o(imag_sum_o)
  );

  dbra_post u_post (
    .clk_i, .rst_ni,
    .start_i(cmd.post_start), .real_i(real_sum_o), .imag_i(imag_sum_o),
    .done_o(status.post_done), .magnitude_o, .phase_o
  );

endmodule
